FILE: sv/ctw_pkg.sv
// ---------------------------------------------------------------------------
// ctw_pkg
// Shared types and constants of the capacitive touch wake detector.
// ---------------------------------------------------------------------------
package ctw_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TOUCH_W = 16;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned DEB_W   = 8;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned BASE_W  = TOUCH_W + FRAC_W;
  localparam int unsigned EMA_SHIFT = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // floor(x / 10) for 16-bit x as (x * 52429) >> 19
  localparam logic [31:0] TENTH_MUL = 32'd52429;
  localparam int unsigned TENTH_SHIFT = 19;

  localparam logic [TIME_W-1:0]  SAMPLE_INTERVAL_RST = 32'd50;
  localparam logic [DELTA_W-1:0] MIN_DELTA_RST       = 16'd20;
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST        = 8'd2;
  localparam logic [TIME_W-1:0]  ON_TIME_RST         = 32'd30000;
  localparam logic [TIME_W-1:0]  RECAL_RST           = 32'd60000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_INTERVAL = 3'd0,
    CFG_MIN_DELTA       = 3'd1,
    CFG_DEBOUNCE        = 3'd2,
    CFG_ON_TIME         = 3'd3,
    CFG_RECAL           = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_ON      = 2'd1,
    CMD_MONITOR = 2'd2,
    CMD_ENERGY  = 2'd3
  } disp_cmd_t;

endpackage

FILE: sv/ctw_in_if.sv
// ---------------------------------------------------------------------------
// ctw_in_if
// Sample channel: timestamp, reading and display status.
// ---------------------------------------------------------------------------
interface ctw_in_if import ctw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   now_ms;
  logic [TOUCH_W-1:0]  touch_value;
  logic                display_is_on;
  logic                display_mode;

  modport source (output valid, now_ms, touch_value, display_is_on, display_mode,
                  input ready);
  modport sink (input valid, now_ms, touch_value, display_is_on, display_mode,
                output ready);
endinterface

FILE: sv/ctw_out_if.sv
// ---------------------------------------------------------------------------
// ctw_out_if
// Result channel: sample decision, wake and display requests.
// ---------------------------------------------------------------------------
interface ctw_out_if import ctw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                sampled;
  logic                below_threshold;
  logic                wake_event;
  disp_cmd_t           display_command;
  logic                turn_off;
  logic                recalibrated;
  logic [TOUCH_W-1:0]  baseline_out;
  logic [TOUCH_W-1:0]  threshold_out;

  modport source (output valid, sampled, below_threshold, wake_event, display_command,
                  turn_off, recalibrated, baseline_out, threshold_out,
                  input ready);
  modport sink (input valid, sampled, below_threshold, wake_event, display_command,
                turn_off, recalibrated, baseline_out, threshold_out,
                output ready);
endinterface

FILE: sv/capacitive_touch_wake_detector.sv
// ---------------------------------------------------------------------------
// capacitive_touch_wake_detector
// Baseline-tracking touch detector with debounce, wake and on-timer.
// ---------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  sample    in   valid/ready    now_ms, touch_value, display_is_on, display_mode
//  result    out  valid/ready    sampled .. threshold_out
//  cfg       in   cfg_we         cfg_index, cfg_wdata
//
//  One beat per cycle sustained while the result side takes beats.
//  The whole step sits between the input register and the result register;
//  the feedback loop through the baseline and timer state sets the cycle.
//  Result stall holds the input register; the sample side keeps taking a beat
//  while a result waits, until the input register is also full.
//  rst is synchronous; it clears state and restores register defaults.
// ---------------------------------------------------------------------------
module capacitive_touch_wake_detector import ctw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  ctw_in_if.sink                 sample,
  ctw_out_if.source              result
);

  // configuration
  logic [TIME_W-1:0]  sample_interval_ms;
  logic [DELTA_W-1:0] min_delta;
  logic [DEB_W-1:0]   debounce_count;
  logic [TIME_W-1:0]  display_on_time_ms;
  logic [TIME_W-1:0]  recalibration_ms;

  // state
  logic [BASE_W-1:0]  baseline_fixed, baseline_fixed_next;
  logic [TIME_W-1:0]  last_sample_time;
  logic [TIME_W-1:0]  touch_start_time, touch_start_time_next;
  logic [DEB_W-1:0]   hit_count, hit_count_next;
  logic               event_latched, event_latched_next;
  logic [TIME_W-1:0]  wake_deadline, wake_deadline_next;

  // input register
  logic               in_valid;
  logic [TIME_W-1:0]  in_now;
  logic [TOUCH_W-1:0] in_touch;
  logic               in_disp_on;
  logic               in_mode;

  // result register
  logic               res_valid;
  logic               res_sampled;
  logic               res_below;
  logic               res_wake;
  disp_cmd_t          res_cmd;
  logic               res_off;
  logic               res_recal;
  logic [TOUCH_W-1:0] res_base;
  logic [TOUCH_W-1:0] res_thr;

  logic               take;
  logic               advance;

  // step logic
  logic               due;
  logic [BASE_W:0]    base_sum;
  logic [TOUCH_W-1:0] base;
  logic [31:0]        tenth_prod;
  logic [DELTA_W-1:0] tenth;
  logic [DELTA_W-1:0] delta;
  logic [TOUCH_W-1:0] thr;
  logic [BASE_W-1:0]  touch_fixed;
  logic [BASE_W-1:0]  base_eff;
  logic               above;
  logic signed [BASE_W+1:0] ema_err;
  logic signed [BASE_W+1:0] ema_sum;
  logic [DEB_W-1:0]   hit_inc;
  logic               recal_due;
  logic               below;
  logic               wake;
  disp_cmd_t          cmd;
  logic               recal;
  logic               disp_on_eff;
  logic [TIME_W-1:0]  since_deadline;
  logic               off;

  assign advance      = in_valid && (!res_valid || result.ready);
  assign sample.ready = !in_valid || advance;
  assign take         = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval_ms <= SAMPLE_INTERVAL_RST;
      min_delta          <= MIN_DELTA_RST;
      debounce_count     <= DEBOUNCE_RST;
      display_on_time_ms <= ON_TIME_RST;
      recalibration_ms   <= RECAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_INTERVAL: sample_interval_ms <= cfg_wdata;
        CFG_MIN_DELTA:       min_delta          <= cfg_wdata[DELTA_W-1:0];
        CFG_DEBOUNCE:        debounce_count     <= cfg_wdata[DEB_W-1:0];
        CFG_ON_TIME:         display_on_time_ms <= cfg_wdata;
        CFG_RECAL:           recalibration_ms   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_now     <= sample.now_ms;
      in_touch   <= sample.touch_value;
      in_disp_on <= sample.display_is_on;
      in_mode    <= sample.display_mode;
    end
  end

  // threshold from the stored baseline
  assign due        = (in_now - last_sample_time) >= sample_interval_ms;
  assign base_sum   = {1'b0, baseline_fixed} + (BASE_W+1)'(1 << (FRAC_W - 1));
  assign base       = base_sum[BASE_W] ? {TOUCH_W{1'b1}} : base_sum[BASE_W-1:FRAC_W];
  assign tenth_prod = {{(32-TOUCH_W){1'b0}}, base} * TENTH_MUL;
  assign tenth      = DELTA_W'(tenth_prod[31:TENTH_SHIFT]);
  assign delta      = (tenth < min_delta) ? min_delta : tenth;
  assign thr        = (base <= delta) ? '0 : base - delta;

  // baseline loaded on first sample, then EMA toward untouched readings; reloaded on recalibration
  assign touch_fixed = {in_touch, {FRAC_W{1'b0}}};
  assign base_eff    = (baseline_fixed == '0) ? touch_fixed : baseline_fixed;
  assign above       = in_touch > thr;
  assign ema_err     = $signed({2'b00, touch_fixed}) - $signed({2'b00, base_eff});
  assign ema_sum     = $signed({2'b00, base_eff}) + (ema_err >>> EMA_SHIFT);
  assign hit_inc     = (hit_count < debounce_count) ? hit_count + 1'b1 : hit_count;
  assign recal_due   = (in_now - touch_start_time) >= recalibration_ms;

  always_comb begin
    baseline_fixed_next   = base_eff;
    touch_start_time_next = touch_start_time;
    hit_count_next        = hit_count;
    event_latched_next    = event_latched;
    wake_deadline_next    = wake_deadline;
    below       = 1'b0;
    wake        = 1'b0;
    cmd         = CMD_NONE;
    recal       = 1'b0;
    disp_on_eff = in_disp_on;
    if (above) begin
      baseline_fixed_next   = ema_sum[BASE_W-1:0];
      hit_count_next        = '0;
      event_latched_next    = 1'b0;
      touch_start_time_next = '0;
    end else begin
      below          = 1'b1;
      hit_count_next = hit_inc;
      if (touch_start_time == '0) begin
        touch_start_time_next = in_now;
      end else if (recal_due) begin
        baseline_fixed_next   = touch_fixed;
        hit_count_next        = '0;
        event_latched_next    = 1'b0;
        touch_start_time_next = '0;
        recal                 = 1'b1;
      end
      if (!event_latched_next && hit_count_next >= debounce_count) begin
        event_latched_next = 1'b1;
        wake               = 1'b1;
        wake_deadline_next = in_now + display_on_time_ms;
        if (in_disp_on) begin
          cmd = in_mode ? CMD_MONITOR : CMD_ENERGY;
        end else begin
          cmd         = CMD_ON;
          disp_on_eff = 1'b1;
        end
      end
    end
    since_deadline = in_now - wake_deadline_next;
    off = (wake_deadline_next != '0) && disp_on_eff && !since_deadline[TIME_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_fixed   <= '0;
      last_sample_time <= '0;
      touch_start_time <= '0;
      hit_count        <= '0;
      event_latched    <= 1'b0;
      wake_deadline    <= '0;
    end else if (advance && due) begin
      baseline_fixed   <= baseline_fixed_next;
      last_sample_time <= in_now;
      touch_start_time <= touch_start_time_next;
      hit_count        <= hit_count_next;
      event_latched    <= event_latched_next;
      wake_deadline    <= wake_deadline_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_sampled <= due;
      res_below   <= due && below;
      res_wake    <= due && wake;
      res_cmd     <= due ? cmd : CMD_NONE;
      res_off     <= due && off;
      res_recal   <= due && recal;
      res_base    <= due ? base : '0;
      res_thr     <= due ? thr : '0;
    end
  end

  assign result.valid           = res_valid;
  assign result.sampled         = res_sampled;
  assign result.below_threshold = res_below;
  assign result.wake_event      = res_wake;
  assign result.display_command = res_cmd;
  assign result.turn_off        = res_off;
  assign result.recalibrated    = res_recal;
  assign result.baseline_out    = res_base;
  assign result.threshold_out   = res_thr;

  a_skipped_is_blank: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_sampled |-> !res_below && !res_wake && !res_off && !res_recal &&
      res_cmd == CMD_NONE && res_base == '0 && res_thr == '0)
    else $error("skipped beat carries nonzero fields");

  a_wake_has_cmd: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_wake |-> res_below && res_cmd != CMD_NONE)
    else $error("wake without below or command");

  a_cmd_needs_wake: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_cmd != CMD_NONE |-> res_wake)
    else $error("command without wake");

  a_recal_below: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_recal |-> res_below)
    else $error("recalibration on untouched reading");

  a_advance_valid: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("advanced beat lost");

  a_turn_off_armed: assert property (@(posedge clk) disable iff (rst)
    advance && due && off |=> wake_deadline != '0)
    else $error("turn-off with disarmed timer");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the capacitive touch wake detector. A cycle-free
// model of the baseline tracker, debounce, recalibration and on-timer
// predicts one decision per sample beat. Every result beat is checked
// against the oldest pending decision. Directed beats hit the special cases
// first. Random touch and release runs follow, with early beats and noise,
// under several register settings including both extremes. Both channels
// idle at random.
// ---------------------------------------------------------------------------
module testbench;
  import ctw_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic [TOUCH_W-1:0] touch_value;
    logic               display_is_on;
    logic               display_mode;
  } sample_beat_t;

  typedef struct packed {
    logic               sampled;
    logic               below;
    logic               wake;
    disp_cmd_t          cmd;
    logic               turn_off;
    logic               recal;
    logic [TOUCH_W-1:0] baseline;
    logic [TOUCH_W-1:0] threshold;
  } decision_t;

  class touch_tracker;
    logic [TIME_W-1:0]  interval;
    logic [DELTA_W-1:0] min_delta;
    logic [DEB_W-1:0]   deb;
    logic [TIME_W-1:0]  on_time;
    logic [TIME_W-1:0]  recal_time;

    logic [BASE_W-1:0]  base_q;
    logic [TIME_W-1:0]  last_t;
    logic [TIME_W-1:0]  touch_t;
    logic [DEB_W-1:0]   hits;
    logic               latched;
    logic [TIME_W-1:0]  deadline;

    decision_t decisions_due[$];
    int unsigned errors, beats, ignored, wakes, recals, offs;

    function new();
      interval   = SAMPLE_INTERVAL_RST;
      min_delta  = MIN_DELTA_RST;
      deb        = DEBOUNCE_RST;
      on_time    = ON_TIME_RST;
      recal_time = RECAL_RST;
      base_q = '0;
      last_t = '0;
      touch_t = '0;
      hits = '0;
      latched = 1'b0;
      deadline = '0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_SAMPLE_INTERVAL: interval = v;
        CFG_MIN_DELTA:       min_delta = v[DELTA_W-1:0];
        CFG_DEBOUNCE:        deb = v[DEB_W-1:0];
        CFG_ON_TIME:         on_time = v;
        CFG_RECAL:           recal_time = v;
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return decisions_due.size();
    endfunction

    function void take_sample(sample_beat_t s);
      decision_t d;
      logic [TIME_W-1:0]  elapsed, since_deadline;
      logic [31:0]        rounded;
      logic [TOUCH_W-1:0] delta;
      longint             err, nb, scaled, cur;
      logic               on;
      d = '0;
      on = s.display_is_on;
      beats++;
      elapsed = s.now_ms - last_t;
      if (elapsed < interval) begin
        ignored++;
        decisions_due.push_back(d);
        return;
      end
      last_t = s.now_ms;
      d.sampled = 1'b1;

      rounded = ({8'd0, base_q} + 32'd128) >> FRAC_W;
      d.baseline = (rounded > 32'hFFFF) ? 16'hFFFF : rounded[TOUCH_W-1:0];
      delta = d.baseline / 16'd10;
      if (delta < min_delta) delta = min_delta;
      d.threshold = (d.baseline <= delta) ? '0 : d.baseline - delta;
      if (base_q == '0) base_q = {s.touch_value, 8'h00};

      if (s.touch_value > d.threshold) begin
        scaled = longint'({s.touch_value, 8'h00});
        cur = longint'(base_q);
        err = scaled - cur;
        nb = cur + (err >>> EMA_SHIFT);
        if (nb < 0) nb = 0;
        if (nb > 64'hFF_FFFF) nb = 64'hFF_FFFF;
        base_q = nb[BASE_W-1:0];
        hits = '0;
        latched = 1'b0;
        touch_t = '0;
      end else begin
        d.below = 1'b1;
        if (hits < deb) hits++;
        if (touch_t == '0) begin
          touch_t = s.now_ms;
        end else if (s.now_ms - touch_t >= recal_time) begin
          base_q = {s.touch_value, 8'h00};
          hits = '0;
          latched = 1'b0;
          touch_t = '0;
          d.recal = 1'b1;
        end
        if (!latched && hits >= deb) begin
          latched = 1'b1;
          d.wake = 1'b1;
          deadline = s.now_ms + on_time;
          if (on) begin
            d.cmd = s.display_mode ? CMD_MONITOR : CMD_ENERGY;
          end else begin
            d.cmd = CMD_ON;
            on = 1'b1;
          end
        end
      end

      since_deadline = s.now_ms - deadline;
      if (deadline != '0 && on && !since_deadline[TIME_W-1]) d.turn_off = 1'b1;
      wakes += d.wake;
      recals += d.recal;
      offs += d.turn_off;
      decisions_due.push_back(d);
    endfunction

    function void match_decision(decision_t got);
      decision_t want;
      if (decisions_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result beat with nothing pending: %p", $realtime, got);
        return;
      end
      want = decisions_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch", $realtime);
          $display("  exp smp=%b blw=%b wake=%b cmd=%0d off=%b rcl=%b base=%0d thr=%0d",
                   want.sampled, want.below, want.wake, want.cmd, want.turn_off,
                   want.recal, want.baseline, want.threshold);
          $display("  got smp=%b blw=%b wake=%b cmd=%0d off=%b rcl=%b base=%0d thr=%0d",
                   got.sampled, got.below, got.wake, got.cmd, got.turn_off,
                   got.recal, got.baseline, got.threshold);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ctw_in_if  sample_ch();
  ctw_out_if result_ch();

  capacitive_touch_wake_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  touch_tracker      tracker;
  bit                calm;
  logic [TIME_W-1:0] cursor;
  int unsigned       settings;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    sample_beat_t s;
    decision_t    r;
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready) begin
        s.now_ms        = sample_ch.now_ms;
        s.touch_value   = sample_ch.touch_value;
        s.display_is_on = sample_ch.display_is_on;
        s.display_mode  = sample_ch.display_mode;
        tracker.take_sample(s);
      end
      if (result_ch.valid && result_ch.ready) begin
        r.sampled   = result_ch.sampled;
        r.below     = result_ch.below_threshold;
        r.wake      = result_ch.wake_event;
        r.cmd       = result_ch.display_command;
        r.turn_off  = result_ch.turn_off;
        r.recal     = result_ch.recalibrated;
        r.baseline  = result_ch.baseline_out;
        r.threshold = result_ch.threshold_out;
        tracker.match_decision(r);
      end
    end
  end

  // result side back-pressure
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    result_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  task automatic send_sample(input logic [TIME_W-1:0] t, input logic [TOUCH_W-1:0] v,
                             input logic on, input logic mode);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (t - cursor >= tracker.interval) cursor = t;
    @(negedge clk);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.now_ms        <= t;
    sample_ch.touch_value   <= v;
    sample_ch.display_is_on <= on;
    sample_ch.display_mode  <= mode;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, v);
  endtask

  task automatic configure(input logic [31:0] interval, input logic [15:0] min_delta,
                           input logic [7:0] deb, input logic [31:0] on_time,
                           input logic [31:0] recal_time);
    drain();
    set_reg(CFG_SAMPLE_INTERVAL, interval);
    set_reg(CFG_MIN_DELTA, {16'd0, min_delta});
    set_reg(CFG_DEBOUNCE, {24'd0, deb});
    set_reg(CFG_ON_TIME, on_time);
    set_reg(CFG_RECAL, recal_time);
    settings++;
  endtask

  // touch/release runs with random content, plus early beats and noise
  task automatic run_phase(input int n, input logic [15:0] level);
    logic [TIME_W-1:0]  t, room;
    logic [TOUCH_W-1:0] v;
    int                 run_left, kind, j;
    bit                 touching;
    run_left = 0;
    touching = 1'b0;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) == 0) calm = !calm;
      kind = $urandom_range(0, 99);
      if (kind < 8 && tracker.interval != 0) begin
        t = cursor + $urandom_range(0, tracker.interval - 1);
        v = 16'($urandom);
      end else if (kind < 18) begin
        t = $urandom;
        v = 16'($urandom);
      end else begin
        if (run_left == 0) begin
          touching = !touching;
          if (!touching) run_left = $urandom_range(1, 6);
          else if ($urandom_range(0, 1) != 0) run_left = tracker.deb + $urandom_range(0, 4);
          else run_left = $urandom_range(1, tracker.deb + 1);
        end
        run_left--;
        room = ~tracker.interval;
        t = cursor + tracker.interval + $urandom_range(0, (room < 20) ? room : 20);
        if (touching) begin
          v = ($urandom_range(0, 3) == 0) ? '0 : 16'(level * $urandom_range(1, 60) / 100);
        end else begin
          j = int'(level) + int'($urandom_range(0, level / 10 + 1)) - int'(level / 20);
          if (j > 65535) j = 65535;
          v = j[15:0];
        end
      end
      send_sample(t, v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    tracker = new();
    calm = 1'b0;
    cursor = '0;
    settings = 1;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_SAMPLE_INTERVAL;
    cfg_wdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.now_ms = '0;
    sample_ch.touch_value = '0;
    sample_ch.display_is_on = 1'b0;
    sample_ch.display_mode = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset register values
    send_sample(32'd0, 16'd1000, 1'b0, 1'b0);        // too early after reset
    send_sample(32'd50, 16'd1000, 1'b0, 1'b0);       // loads baseline
    send_sample(32'd100, 16'd1000, 1'b0, 1'b0);
    send_sample(32'd150, 16'd0, 1'b0, 1'b0);
    send_sample(32'd200, 16'd0, 1'b0, 1'b0);         // wake, turn on
    send_sample(32'd220, 16'd0, 1'b1, 1'b1);         // too early
    send_sample(32'd250, 16'hFFFF, 1'b1, 1'b0);
    send_sample(32'd300, 16'd500, 1'b1, 1'b0);
    send_sample(32'd350, 16'd500, 1'b1, 1'b0);       // wake, energy mode
    send_sample(32'd400, 16'd2000, 1'b1, 1'b1);
    send_sample(32'd450, 16'd500, 1'b1, 1'b1);
    send_sample(32'd500, 16'd500, 1'b1, 1'b1);       // wake, monitor mode
    send_sample(32'd30500, 16'd500, 1'b1, 1'b1);     // timer expires
    send_sample(32'd30550, 16'd500, 1'b0, 1'b0);     // display already off
    send_sample(32'd90550, 16'd500, 1'b1, 1'b0);     // long hold recalibrates
    send_sample(32'hFFFF_FFC0, 16'd2000, 1'b0, 1'b0);
    send_sample(32'd0, 16'd100, 1'b0, 1'b0);         // touch starts at time zero
    send_sample(32'd50, 16'd100, 1'b0, 1'b0);
    send_sample(32'd100, 16'hFFFF, 1'b1, 1'b0);
    send_sample(32'hFFFF_8A9E, 16'd0, 1'b1, 1'b0);
    send_sample(32'hFFFF_8AD0, 16'd0, 1'b1, 1'b0);   // deadline wraps to zero
    send_sample(32'hFFFF_FFFF, 16'd0, 1'b1, 1'b1);

    configure(32'd50, 16'd20, 8'd2, 32'd300, 32'd2000);
    run_phase(180, 16'd1000);
    configure(32'd0, 16'd0, 8'd0, 32'd0, 32'd0);
    run_phase(180, 16'd300);
    configure(32'hFFFF_FFFF, 16'd0, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(400, 16'd40000);
    configure(32'd1, 16'hFFFF, 8'd1, 32'd100, 32'd5000);
    run_phase(150, 16'd65535);
    configure(32'd10, 16'd100, 8'd3, 32'd1000, 32'd300);
    run_phase(180, 16'd5000);
    configure(32'd20, 16'd5, 8'd8, 32'd50000, 32'd100000);
    run_phase(180, 16'd150);
    configure($urandom_range(0, 100), 16'($urandom_range(0, 2000)),
              8'($urandom_range(0, 6)), $urandom_range(0, 2000), $urandom_range(0, 3000));
    run_phase(180, 16'($urandom_range(50, 60000)));

    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d beats (%0d ignored as early) over %0d register settings;",
             tracker.beats, tracker.ignored, settings);
    $display("  %0d wake events, %0d recalibrations, %0d turn-off requests, %0d errors.",
             tracker.wakes, tracker.recals, tracker.offs, tracker.errors);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
